// ===== src/bafom_pkg.sv =====
package bafom_pkg;

  // Field and datapath widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAMP_W = 63;
  localparam int unsigned DIV_N   = 62;   // |dv| * 1e9 stays below 2^62
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] NS_PER_S = 32'sd1000000000;

  // Reset values of the configuration registers
  localparam logic              USE_KIN_RST = 1'b1;
  localparam logic [DATA_W-1:0] MIN_INT_RST = 32'd100000;
  localparam logic [DATA_W-1:0] MAX_INT_RST = 32'd500000000;

  // Sample kind carried by the command field
  localparam logic CMD_ODOM = 1'b0;
  localparam logic CMD_IMU  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_KIN = 2'd0,
    CFG_MIN_INT = 2'd1,
    CFG_MAX_INT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE_MUL,
    ST_RATE_DIV,
    ST_YAW_MUL,
    ST_YAW_ACC
  } st_e;

  // Clamp a 64-bit value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/bafom_div.sv =====
module bafom_div
  import bafom_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_N-1:0]  dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_N-1:0]  quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_N-1:0]  num_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] dvsr_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] trial;
  logic              borrow;

  // One restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_q, num_q[DIV_N-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr_q};
    borrow  = trial[DATA_W+1];
  end

  // Control: run DIV_N steps after start, then pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_N - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  // Datapath: quotient bits collect in the low end of the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_N-2:0], ~borrow};
      rem_q <= borrow ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

// ===== src/body_accel_from_odometry_merge.sv =====
// Inertial sample: result is registered and offered in the cycle after the transfer.
// Odometry sample: stored in the transfer cycle; with a usable interval the
// derivation keeps the input stalled until it ends (two 62-step serial
// divisions plus multiply and accumulate steps on one shared multiplier).
// Throughput: one inertial sample per cycle unless the output or a derivation stalls it.
// Reset clears previous-sample and derived-valid marks and loads register defaults.
module body_accel_from_odometry_merge
  import bafom_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [DATA_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic                      sample_valid_i,
  input  logic [STAMP_W-1:0]        odo_stamp_i,
  input  logic signed [DATA_W-1:0]  vel_x_i,
  input  logic signed [DATA_W-1:0]  vel_y_i,
  input  logic signed [DATA_W-1:0]  yaw_rate_i,
  input  logic signed [DATA_W-1:0]  accel_x_i,
  input  logic signed [DATA_W-1:0]  accel_y_i,
  input  logic signed [DATA_W-1:0]  accel_z_i,
  input  logic signed [DATA_W-1:0]  gyro_x_i,
  input  logic signed [DATA_W-1:0]  gyro_y_i,
  input  logic signed [DATA_W-1:0]  gyro_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DATA_W-1:0]  out_accel_x_o,
  output logic signed [DATA_W-1:0]  out_accel_y_o,
  output logic signed [DATA_W-1:0]  out_accel_z_o,
  output logic signed [DATA_W-1:0]  out_gyro_x_o,
  output logic signed [DATA_W-1:0]  out_gyro_y_o,
  output logic signed [DATA_W-1:0]  out_gyro_z_o,
  output logic                      derived_used_o
);

  // Configuration registers
  logic              use_kin_q;
  logic [DATA_W-1:0] min_int_q;
  logic [DATA_W-1:0] max_int_q;

  // Sequencer and stored state
  st_e st_q, st_d;
  logic                     have_prev_q;
  logic                     der_valid_q;
  logic                     side_q;        // 0: x axis, 1: y axis
  logic [STAMP_W-1:0]       prev_stamp_q;
  logic signed [DATA_W-1:0] prev_vx_q, prev_vy_q;
  logic signed [DATA_W-1:0] der_ax_q, der_ay_q;
  logic signed [DATA_W-1:0] vx_q, vy_q, wz_q;
  logic signed [DATA_W:0]   dvx_q, dvy_q;
  logic [DATA_W-1:0]        dt_q;
  logic signed [63:0]       acc_q;
  logic signed [63:0]       prod_q;

  // Output register
  logic                     out_valid_q;
  logic                     der_used_q;
  logic signed [DATA_W-1:0] o_ax_q, o_ay_q, o_az_q, o_gx_q, o_gy_q, o_gz_q;

  // Combinational signals
  logic                     in_xfer, odo_xfer, imu_xfer;
  logic [63:0]              diff;
  logic                     in_range;
  logic signed [DATA_W:0]   dv_sel, mag;
  logic signed [DATA_W:0]   mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [2*DATA_W:0] mul_p;
  logic                     div_start, div_done;
  logic [DIV_N-1:0]         quo;
  logic signed [63:0]       quo_ext, yaw_term, acc_sum;

  assign in_stall_o = (st_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign odo_xfer   = in_xfer && sample_valid_i && (command_i == CMD_ODOM);
  assign imu_xfer   = in_xfer && sample_valid_i && (command_i == CMD_IMU);

  // Interval check against the stored stamp
  always_comb begin
    diff     = {1'b0, odo_stamp_i} - {1'b0, prev_stamp_q};
    in_range = !diff[63] && (diff[62:DATA_W] == '0)
               && (diff[DATA_W-1:0] > min_int_q) && (diff[DATA_W-1:0] < max_int_q);
  end

  // Shared multiplier: |dv| * 1e9 for the rate, yaw rate * velocity for the turn term
  always_comb begin
    dv_sel = side_q ? dvy_q : dvx_q;
    mag    = dv_sel[DATA_W] ? -dv_sel : dv_sel;
    if (st_q == ST_YAW_MUL) begin
      mul_a = side_q ? {vx_q[DATA_W-1], vx_q} : {vy_q[DATA_W-1], vy_q};
      mul_b = wz_q;
    end else begin
      mul_a = mag;
      mul_b = NS_PER_S;
    end
    mul_p = (2*DATA_W+1)'(mul_a) * (2*DATA_W+1)'(mul_b);
  end

  assign div_start = (st_q == ST_RATE_MUL);

  bafom_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p[DIV_N-1:0]),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Signed rate and the accumulate step (floor shift of the turn term)
  always_comb begin
    quo_ext  = {{(64-DIV_N){1'b0}}, quo};
    yaw_term = prod_q >>> 16;
    acc_sum  = side_q ? (acc_q + yaw_term) : (acc_q - yaw_term);
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (odo_xfer && have_prev_q && in_range) begin
          st_d = ST_RATE_MUL;
        end
      end
      ST_RATE_MUL: st_d = ST_RATE_DIV;
      ST_RATE_DIV: begin
        if (div_done) begin
          st_d = ST_YAW_MUL;
        end
      end
      ST_YAW_MUL:  st_d = ST_YAW_ACC;
      ST_YAW_ACC:  st_d = side_q ? ST_IDLE : ST_RATE_MUL;
      default:     st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_kin_q <= USE_KIN_RST;
      min_int_q <= MIN_INT_RST;
      max_int_q <= MAX_INT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_USE_KIN: use_kin_q <= cfg_data_i[0];
        CFG_MIN_INT: min_int_q <= cfg_data_i;
        CFG_MAX_INT: max_int_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control flags: previous-sample mark, derived-valid mark, axis select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      der_valid_q <= 1'b0;
      side_q      <= 1'b0;
    end else begin
      if (odo_xfer) begin
        have_prev_q <= 1'b1;
        side_q      <= 1'b0;
        if (have_prev_q && !in_range) begin
          der_valid_q <= 1'b0;
        end
      end
      if (st_q == ST_YAW_ACC) begin
        side_q <= 1'b1;
        if (side_q) begin
          der_valid_q <= 1'b1;
        end
      end
    end
  end

  // Odometry capture and derivation datapath
  always_ff @(posedge clk_i) begin
    if (odo_xfer) begin
      prev_stamp_q <= odo_stamp_i;
      prev_vx_q    <= vel_x_i;
      prev_vy_q    <= vel_y_i;
      vx_q         <= vel_x_i;
      vy_q         <= vel_y_i;
      wz_q         <= yaw_rate_i;
      dvx_q        <= {vel_x_i[DATA_W-1], vel_x_i} - {prev_vx_q[DATA_W-1], prev_vx_q};
      dvy_q        <= {vel_y_i[DATA_W-1], vel_y_i} - {prev_vy_q[DATA_W-1], prev_vy_q};
      dt_q         <= diff[DATA_W-1:0];
    end
    if ((st_q == ST_RATE_DIV) && div_done) begin
      acc_q <= dv_sel[DATA_W] ? -quo_ext : quo_ext;
    end
    if (st_q == ST_YAW_MUL) begin
      prod_q <= mul_p[63:0];
    end
    if (st_q == ST_YAW_ACC) begin
      if (side_q) begin
        der_ay_q <= sat32(acc_sum);
      end else begin
        der_ax_q <= sat32(acc_sum);
      end
    end
  end

  // Output register: load on an inertial transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (imu_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imu_xfer) begin
      der_used_q <= use_kin_q && der_valid_q;
      o_ax_q     <= (use_kin_q && der_valid_q) ? der_ax_q : accel_x_i;
      o_ay_q     <= (use_kin_q && der_valid_q) ? der_ay_q : accel_y_i;
      o_az_q     <= accel_z_i;
      o_gx_q     <= gyro_x_i;
      o_gy_q     <= gyro_y_i;
      o_gz_q     <= gyro_z_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_accel_x_o  = o_ax_q;
  assign out_accel_y_o  = o_ay_q;
  assign out_accel_z_o  = o_az_q;
  assign out_gyro_x_o   = o_gx_q;
  assign out_gyro_y_o   = o_gy_q;
  assign out_gyro_z_o   = o_gz_q;
  assign derived_used_o = der_used_q;

endmodule

// ===== dv/body_accel_from_odometry_merge_tb.sv =====
module body_accel_from_odometry_merge_tb;
  import bafom_pkg::*;

  localparam int unsigned     DRAIN_CYCLES   = 200;
  localparam int unsigned     WATCHDOG_LIMIT = 2000;
  localparam longint unsigned NS_PER_SEC     = 64'd1000000000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  // index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic                     command;
    logic                     sample_valid;
    logic [STAMP_W-1:0]       stamp;
    logic signed [DATA_W-1:0] vel_x, vel_y, yaw_rate;
    logic signed [DATA_W-1:0] accel_x, accel_y, accel_z;
    logic signed [DATA_W-1:0] gyro_x, gyro_y, gyro_z;
  } sample_t;

  typedef struct {
    logic signed [DATA_W-1:0] accel_x, accel_y, accel_z;
    logic signed [DATA_W-1:0] gyro_x, gyro_y, gyro_z;
    logic                     derived_used;
  } imu_result_t;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx  = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall_o;
  logic                     command  = 1'b0;
  logic                     sample_valid = 1'b0;
  logic [STAMP_W-1:0]       odo_stamp = '0;
  logic signed [DATA_W-1:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
  logic signed [DATA_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [DATA_W-1:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_accel_x_o, out_accel_y_o, out_accel_z_o;
  logic signed [DATA_W-1:0] out_gyro_x_o, out_gyro_y_o, out_gyro_z_o;
  logic                     derived_used_o;

  // predictor copy of registers and state
  logic                     kin_enable    = USE_KIN_RST;
  logic [DATA_W-1:0]        min_gap_ns    = MIN_INT_RST;
  logic [DATA_W-1:0]        max_gap_ns    = MAX_INT_RST;
  logic                     odom_seen     = 1'b0;
  logic [STAMP_W-1:0]       last_odom_stamp = '0;
  logic signed [DATA_W-1:0] last_vel_x    = '0;
  logic signed [DATA_W-1:0] last_vel_y    = '0;
  logic                     body_accel_ok = 1'b0;
  logic signed [DATA_W-1:0] body_accel_x  = '0;
  logic signed [DATA_W-1:0] body_accel_y  = '0;
  imu_result_t              merged_imu_q[$];

  // stimulus bookkeeping
  logic [STAMP_W-1:0] sent_stamp     = '0;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        quiet_cycles   = 0;
  int                 fail_count     = 0;

  body_accel_from_odometry_merge u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .command_i      (command),
    .sample_valid_i (sample_valid),
    .odo_stamp_i    (odo_stamp),
    .vel_x_i        (vel_x),
    .vel_y_i        (vel_y),
    .yaw_rate_i     (yaw_rate),
    .accel_x_i      (accel_x),
    .accel_y_i      (accel_y),
    .accel_z_i      (accel_z),
    .gyro_x_i       (gyro_x),
    .gyro_y_i       (gyro_y),
    .gyro_z_i       (gyro_z),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .out_accel_x_o  (out_accel_x_o),
    .out_accel_y_o  (out_accel_y_o),
    .out_accel_z_o  (out_accel_z_o),
    .out_gyro_x_o   (out_gyro_x_o),
    .out_gyro_y_o   (out_gyro_y_o),
    .out_gyro_z_o   (out_gyro_z_o),
    .derived_used_o (derived_used_o)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // velocity change per interval, in Q16.16 per second, truncated toward zero
  function automatic longint rate_q16(input longint dv, input longint dt);
    longint unsigned mag;
    longint unsigned quo;
    mag = (dv < 0) ? -dv : dv;
    quo = (mag * NS_PER_SEC) / dt;
    return (dv < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // Q16.16 product, floored
  function automatic longint yaw_term(input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Advance the predictor by one accepted sample
  function automatic void merge_sample(input sample_t s);
    longint      dt;
    longint      acc_x;
    longint      acc_y;
    logic        use_body;
    imu_result_t r;
    if (!s.sample_valid) return;
    if (s.command == CMD_ODOM) begin
      if (odom_seen) begin
        dt = longint'({1'b0, s.stamp}) - longint'({1'b0, last_odom_stamp});
        if (dt > longint'({32'd0, min_gap_ns}) && dt < longint'({32'd0, max_gap_ns})) begin
          acc_x = rate_q16(longint'(s.vel_x) - longint'(last_vel_x), dt)
                - yaw_term(s.yaw_rate, s.vel_y);
          acc_y = rate_q16(longint'(s.vel_y) - longint'(last_vel_y), dt)
                + yaw_term(s.yaw_rate, s.vel_x);
          body_accel_x  = clamp_q16(acc_x);
          body_accel_y  = clamp_q16(acc_y);
          body_accel_ok = 1'b1;
        end else begin
          body_accel_ok = 1'b0;
        end
      end
      last_odom_stamp = s.stamp;
      last_vel_x      = s.vel_x;
      last_vel_y      = s.vel_y;
      odom_seen       = 1'b1;
    end else begin
      use_body       = kin_enable && body_accel_ok;
      r.accel_x      = use_body ? body_accel_x : s.accel_x;
      r.accel_y      = use_body ? body_accel_y : s.accel_y;
      r.accel_z      = s.accel_z;
      r.gyro_x       = s.gyro_x;
      r.gyro_y       = s.gyro_y;
      r.gyro_z       = s.gyro_z;
      r.derived_used = use_body;
      merged_imu_q.push_back(r);
    end
  endfunction

  // random value with a random magnitude, full scale included
  function automatic logic signed [DATA_W-1:0] rand_q16();
    return $signed($urandom) >>> $urandom_range(24);
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[STAMP_W-1:0];
  endfunction

  // inertial sample with random content in every data field
  function automatic sample_t rand_imu(input logic ok);
    sample_t s;
    s.command      = CMD_IMU;
    s.sample_valid = ok;
    s.stamp        = rand_stamp();
    s.vel_x        = rand_q16();
    s.vel_y        = rand_q16();
    s.yaw_rate     = rand_q16();
    s.accel_x      = rand_q16();
    s.accel_y      = rand_q16();
    s.accel_z      = rand_q16();
    s.gyro_x       = rand_q16();
    s.gyro_y       = rand_q16();
    s.gyro_z       = rand_q16();
    return s;
  endfunction

  function automatic sample_t make_imu(input logic ok,
                                       input logic signed [DATA_W-1:0] ax, ay, az,
                                       input logic signed [DATA_W-1:0] gx, gy, gz);
    sample_t s;
    s         = rand_imu(ok);
    s.accel_x = ax;
    s.accel_y = ay;
    s.accel_z = az;
    s.gyro_x  = gx;
    s.gyro_y  = gy;
    s.gyro_z  = gz;
    return s;
  endfunction

  // odometry sample; inertial fields carry random noise
  function automatic sample_t make_odom(input logic ok, input logic [STAMP_W-1:0] stamp,
                                        input logic signed [DATA_W-1:0] vx, vy, wz);
    sample_t s;
    s          = rand_imu(ok);
    s.command  = CMD_ODOM;
    s.stamp    = stamp;
    s.vel_x    = vx;
    s.vel_y    = vy;
    s.yaw_rate = wz;
    return s;
  endfunction

  // next odometry interval, mostly inside the current window
  function automatic longint pick_interval();
    longint      lo;
    longint      hi;
    int unsigned pick;
    int unsigned span;
    lo   = longint'({32'd0, min_gap_ns});
    hi   = longint'({32'd0, max_gap_ns});
    pick = $urandom_range(99);
    if (pick < 85 && hi - lo >= 2) begin
      span = 32'(hi - lo - 2);
      if (pick < 45 && span > 5000000) span = 5000000;
      return lo + 1 + $urandom_range(span);
    end
    case (pick % 5)
      0: return lo;
      1: return hi;
      2: return 0;
      3: return -longint'($urandom_range(1000000000, 1));
      default: return hi + $urandom;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // Write one register; the block is idle when this is called
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_USE_KIN: kin_enable = value[0];
      CFG_MIN_INT: min_gap_ns = value;
      CFG_MAX_INT: max_gap_ns = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one sample, with random idle cycles ahead of it, and hold it until transfer
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= s.command;
    sample_valid <= s.sample_valid;
    odo_stamp    <= s.stamp;
    vel_x        <= s.vel_x;
    vel_y        <= s.vel_y;
    yaw_rate     <= s.yaw_rate;
    accel_x      <= s.accel_x;
    accel_y      <= s.accel_y;
    accel_z      <= s.accel_z;
    gyro_x       <= s.gyro_x;
    gyro_y       <= s.gyro_y;
    gyro_z       <= s.gyro_z;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    merge_sample(s);
    if (s.sample_valid && s.command == CMD_ODOM) sent_stamp = s.stamp;
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then let a derivation finish
  task automatic settle();
    in_valid <= 1'b0;
    while (merged_imu_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    // pass-through before any odometry, field extremes both ways
    send_sample(make_imu(1'b1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_sample(make_imu(1'b1, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    // drop invalid inertial, ignore invalid odometry
    send_sample(rand_imu(1'b0));
    send_sample(make_odom(1'b0, 63'd5000, Q_MAX, Q_MAX, Q_MAX));
    // first odometry is only stored
    send_sample(make_odom(1'b1, 63'd1000, 32'sd65536, -32'sd32768, 32'sd6554));
    send_sample(rand_imu(1'b1));
    // 1 ms interval: derive and replace
    send_sample(make_odom(1'b1, 63'd1001000, 32'sd131072, 32'sd0, -32'sd13107));
    send_sample(rand_imu(1'b1));
    // interval equal to the lower bound clears the mark
    send_sample(make_odom(1'b1, 63'd1101000, Q_MAX, Q_MAX, Q_MIN));
    send_sample(rand_imu(1'b1));
    // full-scale swing over the shortest usable interval saturates both axes
    send_sample(make_odom(1'b1, 63'd1201001, Q_MIN, Q_MIN, Q_MIN));
    send_sample(rand_imu(1'b1));
    // extreme yaw rate with no velocity change
    send_sample(make_odom(1'b1, 63'd2201001, Q_MIN, Q_MIN, Q_MAX));
    send_sample(rand_imu(1'b1));
    // zero interval
    send_sample(make_odom(1'b1, 63'd2201001, 32'sd0, 32'sd0, 32'sd0));
    // one below the upper bound, then exactly the upper bound
    send_sample(make_odom(1'b1, 63'd502201000, 32'sd1000, -32'sd1000, 32'sd100));
    send_sample(rand_imu(1'b1));
    send_sample(make_odom(1'b1, 63'd1002201000, 32'sd0, 32'sd0, 32'sd0));
    send_sample(rand_imu(1'b1));
    // valid again, then a step back in time
    send_sample(make_odom(1'b1, 63'd1003201000, 32'sd4000, 32'sd2000, -32'sd700));
    send_sample(make_odom(1'b1, 63'd1003200999, 32'sd0, 32'sd0, 32'sd0));
    send_sample(rand_imu(1'b1));
    // top of the stamp range
    send_sample(make_odom(1'b1, {STAMP_W{1'b1}}, Q_MAX, Q_MIN, 32'sd0));
    send_sample(rand_imu(1'b1));
    settle();
  endtask

  task automatic test_registers();
    logic [STAMP_W-1:0] t;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    t = 63'd4000000000;
    // replacement off: odometry is still tracked
    write_reg(CFG_USE_KIN, 32'd0);
    send_sample(make_odom(1'b1, t, 32'sd70000, -32'sd5000, 32'sd3000));
    t = t + 63'd2000000;
    send_sample(make_odom(1'b1, t, 32'sd50000, 32'sd9000, -32'sd3000));
    send_sample(rand_imu(1'b1));
    settle();
    // replacement back on: held values reappear
    write_reg(CFG_USE_KIN, 32'd1);
    send_sample(rand_imu(1'b1));
    settle();
    // a write past the register list changes nothing
    write_reg(CFG_SPARE, '1);
    send_sample(rand_imu(1'b1));
    settle();
    // widest window: 1 ns up to 2^32-2 ns usable
    write_reg(CFG_MIN_INT, 32'd0);
    write_reg(CFG_MAX_INT, 32'hFFFF_FFFF);
    t = t + 63'd1;
    send_sample(make_odom(1'b1, t, 32'sd3, -32'sd3, 32'sd65536));
    send_sample(rand_imu(1'b1));
    t = t + 63'h0_FFFF_FFFE;
    send_sample(make_odom(1'b1, t, Q_MIN, Q_MAX, -32'sd65536));
    send_sample(rand_imu(1'b1));
    t = t + 63'h0_FFFF_FFFF;
    send_sample(make_odom(1'b1, t, 32'sd0, 32'sd0, 32'sd0));
    send_sample(rand_imu(1'b1));
    settle();
    // empty windows
    write_reg(CFG_MIN_INT, 32'hFFFF_FFFF);
    t = t + 63'd1000000;
    send_sample(make_odom(1'b1, t, 32'sd100, 32'sd100, 32'sd100));
    send_sample(rand_imu(1'b1));
    settle();
    write_reg(CFG_MIN_INT, 32'd0);
    write_reg(CFG_MAX_INT, 32'd0);
    t = t + 63'd1;
    send_sample(make_odom(1'b1, t, 32'sd200, 32'sd200, 32'sd200));
    send_sample(rand_imu(1'b1));
    settle();
    // restore reset values
    write_reg(CFG_USE_KIN, {31'd0, USE_KIN_RST});
    write_reg(CFG_MIN_INT, MIN_INT_RST);
    write_reg(CFG_MAX_INT, MAX_INT_RST);
  endtask

  // Mostly chained odometry with inertial samples in between, some noise
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned send_pct,
                                     input int unsigned stall_pct,
                                     input logic [DATA_W-1:0] lo_ns,
                                     input logic [DATA_W-1:0] hi_ns);
    sample_t     s;
    int unsigned pick;
    logic [63:0] next_stamp;
    write_reg(CFG_USE_KIN, 32'd1);
    write_reg(CFG_MIN_INT, lo_ns);
    write_reg(CFG_MAX_INT, hi_ns);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        s         = make_odom(1'($urandom_range(1)), rand_stamp(), $urandom, $urandom,
                              $urandom);
        s.command = 1'($urandom_range(1));
      end else if (pick < 50) begin
        next_stamp = {1'b0, sent_stamp} + pick_interval();
        s = make_odom($urandom_range(99) < 95, next_stamp[STAMP_W-1:0],
                      rand_q16(), rand_q16(), rand_q16());
      end else begin
        s = rand_imu($urandom_range(99) < 95);
      end
      send_sample(s);
    end
    settle();
  endtask

  // Random stall on the result side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_result
    imu_result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (merged_imu_q.size() == 0) begin
        $error("unexpected result: out_accel_x %h, out_accel_y %h", out_accel_x_o,
               out_accel_y_o);
        fail_count++;
      end else begin
        want = merged_imu_q.pop_front();
        check_field("out_accel_x", want.accel_x, out_accel_x_o);
        check_field("out_accel_y", want.accel_y, out_accel_y_o);
        check_field("out_accel_z", want.accel_z, out_accel_z_o);
        check_field("out_gyro_x", want.gyro_x, out_gyro_x_o);
        check_field("out_gyro_y", want.gyro_y, out_gyro_y_o);
        check_field("out_gyro_z", want.gyro_z, out_gyro_z_o);
        check_field("derived_used", {31'd0, want.derived_used}, {31'd0, derived_used_o});
      end
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("body_accel_from_odometry_merge regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_registers();
    test_random_traffic(670, 30, 84, MIN_INT_RST, MAX_INT_RST);
    test_random_traffic(670, 84, 30, 32'd0, 32'hFFFF_FFFF);
    test_random_traffic(670, 0, 0, $urandom_range(2000000), 32'd2000002 + $urandom_range(1000000000));
    if (fail_count == 0) begin
      $display("body_accel_from_odometry_merge regression: pass");
    end else begin
      $display("body_accel_from_odometry_merge regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bafom_pkg.sv
src/bafom_div.sv
src/body_accel_from_odometry_merge.sv
dv/body_accel_from_odometry_merge_tb.sv
